>>> src/vector3_arithmetic_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define V3ALU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define V3ALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/v3alu_pkg.sv
package v3alu_pkg;

    localparam int W           = 32;
    localparam int F           = 16;
    localparam int OP_W        = 3;
    localparam int PROD_W      = 2 * W;
    localparam int WIDE_W      = 2 * W + 2;
    localparam int SQ_W        = 2 * W;
    localparam int NUM_W       = W + F;
    localparam int SQRT_STAGES = W;
    localparam int DIV_STAGES  = NUM_W;

    typedef logic signed [W-1:0]      word_t;
    typedef logic [W-1:0]             uword_t;
    typedef logic signed [W:0]        addw_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [NUM_W-1:0]         num_t;

    localparam word_t MAX_VAL  = {1'b0, {(W-1){1'b1}}};
    localparam word_t MIN_VAL  = {1'b1, {(W-1){1'b0}}};
    localparam wide_t RND_HALF = wide_t'(1) <<< (F - 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD, OP_SUB, OP_SCALE, OP_DOT, OP_MAG, OP_NORM, OP_CROSS
    } op_t;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t s;
        logic  ovf;
    } res_t;

    // one pipeline slot of the operation and its partial results
    typedef struct packed {
        logic  valid;
        op_t   op;
        word_t ax;
        word_t ay;
        word_t az;
        res_t  res;
        logic  mzero;
    } side_t;

    function automatic sat_t sat_wide(input wide_t v);
        sat_t               r;
        logic [WIDE_W-W:0]  hi;
        hi = v[WIDE_W-1:W-1];
        if (&hi || ~|hi)
        begin
            r.val = word_t'(v[W-1:0]);
            r.ovf = 1'b0;
        end
        else
        begin
            r.val = v[WIDE_W-1] ? MIN_VAL : MAX_VAL;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // round to nearest, ties toward +inf, then saturate
    function automatic sat_t round_sat(input wide_t v);
        wide_t t;
        t = (v + RND_HALF) >>> F;
        return sat_wide(t);
    endfunction

    function automatic uword_t abs_word(input word_t a);
        return a[W-1] ? uword_t'(-a) : uword_t'(a);
    endfunction

    // signed quotient from magnitude q and sign
    function automatic sat_t div_sat(input num_t q, input logic neg);
        sat_t   r;
        uword_t nq;
        logic   big;
        nq = uword_t'(~q[W-1:0]) + uword_t'(1);
        if (!neg)
        begin
            big   = |q[NUM_W-1:W-1];
            r.val = big ? MAX_VAL : word_t'(q[W-1:0]);
        end
        else
        begin
            big   = (|q[NUM_W-1:W]) || (q[W-1] && (|q[W-2:0]));
            r.val = big ? MIN_VAL : word_t'(nq);
        end
        r.ovf = big;
        return r;
    endfunction

endpackage

>>> src/v3alu_if.sv
interface v3alu_in_if;
    logic                            valid;
    logic                            ready;
    logic [v3alu_pkg::OP_W-1:0]      opcode;
    logic signed [v3alu_pkg::W-1:0]  a_x;
    logic signed [v3alu_pkg::W-1:0]  a_y;
    logic signed [v3alu_pkg::W-1:0]  a_z;
    logic signed [v3alu_pkg::W-1:0]  b_x;
    logic signed [v3alu_pkg::W-1:0]  b_y;
    logic signed [v3alu_pkg::W-1:0]  b_z;

    modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface v3alu_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [v3alu_pkg::W-1:0]  res_x;
    logic signed [v3alu_pkg::W-1:0]  res_y;
    logic signed [v3alu_pkg::W-1:0]  res_z;
    logic signed [v3alu_pkg::W-1:0]  res_scalar;
    logic                            overflow;

    modport source (output valid, res_x, res_y, res_z, res_scalar, overflow, input ready);
    modport sink   (input valid, res_x, res_y, res_z, res_scalar, overflow, output ready);
endinterface

>>> src/v3alu_sqrt.sv
// Floor square root, two radicand bits per stage.
module v3alu_sqrt (
    input  logic              clk,
    input  logic              en,
    input  v3alu_pkg::sq_t    rad,
    output v3alu_pkg::uword_t root
);

    typedef logic [v3alu_pkg::W:0]   rem_t;
    typedef logic [v3alu_pkg::W+2:0] trial_t;

    rem_t              rem_reg  [v3alu_pkg::SQRT_STAGES];
    v3alu_pkg::uword_t root_reg [v3alu_pkg::SQRT_STAGES];
    v3alu_pkg::sq_t    rad_reg  [v3alu_pkg::SQRT_STAGES];

    genvar j;
    generate
        for (j = 0; j < v3alu_pkg::SQRT_STAGES; j++)
        begin : g_stage
            rem_t              rem_in;
            v3alu_pkg::uword_t root_in;
            v3alu_pkg::sq_t    rad_in;
            trial_t            trial;
            trial_t            tst;
            trial_t            diff;
            logic              ge;

            if (j == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad;
            end
            else
            begin : g_chain
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
                assign rad_in  = rad_reg[j-1];
            end

            always_comb
            begin
                trial = {rem_in, rad_in[v3alu_pkg::SQ_W-1 -: 2]};
                tst   = {1'b0, root_in, 2'b01};
                diff  = trial - tst;
                ge    = (trial >= tst);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= ge ? diff[v3alu_pkg::W:0] : trial[v3alu_pkg::W:0];
                    root_reg[j] <= {root_in[v3alu_pkg::W-2:0], ge};
                    rad_reg[j]  <= {rad_in[v3alu_pkg::SQ_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[v3alu_pkg::SQRT_STAGES-1];

endmodule

>>> src/v3alu_div.sv
// Restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module v3alu_div (
    input  logic              clk,
    input  logic              en,
    input  v3alu_pkg::num_t   num [3],
    input  v3alu_pkg::uword_t den,
    output v3alu_pkg::num_t   quo [3]
);

    typedef logic [v3alu_pkg::W:0] trial_t;

    // work holds the numerator bits still to go, quotient bits shift in at the bottom
    v3alu_pkg::num_t   work_reg [v3alu_pkg::DIV_STAGES][3];
    v3alu_pkg::uword_t rem_reg  [v3alu_pkg::DIV_STAGES][3];
    v3alu_pkg::uword_t den_reg  [v3alu_pkg::DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < v3alu_pkg::DIV_STAGES; j++)
        begin : g_stage
            v3alu_pkg::num_t   work_in [3];
            v3alu_pkg::uword_t rem_in  [3];
            v3alu_pkg::uword_t den_in;
            trial_t            trial   [3];
            trial_t            diff    [3];
            logic              ge      [3];

            if (j == 0)
            begin : g_first
                assign work_in = num;
                assign rem_in  = '{default: '0};
                assign den_in  = den;
            end
            else
            begin : g_chain
                assign work_in = work_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign den_in  = den_reg[j-1];
            end

            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    trial[k] = {rem_in[k], work_in[k][v3alu_pkg::NUM_W-1]};
                    diff[k]  = trial[k] - {1'b0, den_in};
                    ge[k]    = (trial[k] >= {1'b0, den_in});
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_reg[j][k]  <= ge[k] ? diff[k][v3alu_pkg::W-1:0]
                                                : trial[k][v3alu_pkg::W-1:0];
                        work_reg[j][k] <= {work_in[k][v3alu_pkg::NUM_W-2:0], ge[k]};
                    end
                    den_reg[j] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = work_reg[v3alu_pkg::DIV_STAGES-1];

endmodule

>>> src/vector3_arithmetic_unit.sv
// Pipeline: 2 multiply/sum stages, 32 square-root stages, 48 divider stages and
// 1 output register, the same for every opcode.
// Throughput: one word per cycle; the whole pipeline holds when the output word waits.
// Reset (rst_n low, async) clears all valid bits and side lines; no other data.
module vector3_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    v3alu_in_if.sink    operand,
    v3alu_out_if.source result
);

    logic adv;

    // stage 1: products and add/sub
    logic               v1_reg;
    v3alu_pkg::op_t     op1_reg;
    v3alu_pkg::word_t   a1_reg    [3];
    v3alu_pkg::prod_t   prod_reg  [6];
    v3alu_pkg::addw_t   as1_reg   [3];
    v3alu_pkg::op_t     op_in;
    v3alu_pkg::word_t   a_in      [3];
    v3alu_pkg::word_t   b_in      [3];
    v3alu_pkg::word_t   ma        [6];
    v3alu_pkg::word_t   mb        [6];
    v3alu_pkg::prod_t   prod_next [6];
    v3alu_pkg::addw_t   as1_next  [3];

    // stage 2: sums and differences
    logic               v2_reg;
    v3alu_pkg::op_t     op2_reg;
    v3alu_pkg::word_t   a2_reg    [3];
    v3alu_pkg::wide_t   wide2_reg [3];
    v3alu_pkg::addw_t   as2_reg   [3];
    v3alu_pkg::sq_t     sq2_reg;
    v3alu_pkg::wide_t   dot_sum;
    v3alu_pkg::wide_t   wide2_next[3];

    // stage 3 onward: side line next to the square root and the divider
    v3alu_pkg::side_t   side1_reg [v3alu_pkg::SQRT_STAGES];
    v3alu_pkg::side_t   side2_reg [v3alu_pkg::DIV_STAGES];
    v3alu_pkg::side_t   side1_next;
    v3alu_pkg::side_t   side2_next;
    v3alu_pkg::sat_t    as_sat    [3];
    v3alu_pkg::sat_t    rd_sat    [3];
    v3alu_pkg::uword_t  mag;
    v3alu_pkg::word_t   s1a       [3];
    v3alu_pkg::word_t   s2a       [3];
    v3alu_pkg::num_t    div_num   [3];
    v3alu_pkg::num_t    div_quo   [3];
    v3alu_pkg::sat_t    nrm_sat   [3];

    // output register
    logic               out_valid_reg;
    v3alu_pkg::res_t    out_res_reg;
    v3alu_pkg::res_t    out_res_next;

    assign adv           = !out_valid_reg || result.ready;
    assign operand.ready = adv;

    assign op_in   = v3alu_pkg::op_t'(operand.opcode);
    assign a_in[0] = operand.a_x;
    assign a_in[1] = operand.a_y;
    assign a_in[2] = operand.a_z;
    assign b_in[0] = operand.b_x;
    assign b_in[1] = operand.b_y;
    assign b_in[2] = operand.b_z;

    // cross: x = p0 - p3, y = p1 - p4, z = p2 - p5
    always_comb
    begin
        ma[3] = a_in[2];  mb[3] = b_in[1];
        ma[4] = a_in[0];  mb[4] = b_in[2];
        ma[5] = a_in[1];  mb[5] = b_in[0];
        for (int k = 0; k < 3; k++)
        begin
            ma[k] = a_in[k];
            mb[k] = a_in[k];
        end
        unique case (op_in)
            v3alu_pkg::OP_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                    mb[k] = b_in[0];
            end
            v3alu_pkg::OP_DOT:
            begin
                for (int k = 0; k < 3; k++)
                    mb[k] = b_in[k];
            end
            v3alu_pkg::OP_CROSS:
            begin
                ma[0] = a_in[1];  mb[0] = b_in[2];
                ma[1] = a_in[2];  mb[1] = b_in[0];
                ma[2] = a_in[0];  mb[2] = b_in[1];
            end
            default:
            begin
                // squares for magnitude and normalize
            end
        endcase
        for (int k = 0; k < 6; k++)
            prod_next[k] = ma[k] * mb[k];
        for (int k = 0; k < 3; k++)
            as1_next[k] = (op_in == v3alu_pkg::OP_SUB)
                        ? v3alu_pkg::addw_t'(a_in[k]) - v3alu_pkg::addw_t'(b_in[k])
                        : v3alu_pkg::addw_t'(a_in[k]) + v3alu_pkg::addw_t'(b_in[k]);
    end

    always_comb
    begin
        dot_sum = v3alu_pkg::wide_t'(prod_reg[0]) + v3alu_pkg::wide_t'(prod_reg[1])
                + v3alu_pkg::wide_t'(prod_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            if (op1_reg == v3alu_pkg::OP_CROSS)
                wide2_next[k] = v3alu_pkg::wide_t'(prod_reg[k])
                              - v3alu_pkg::wide_t'(prod_reg[k+3]);
            else
                wide2_next[k] = v3alu_pkg::wide_t'(prod_reg[k]);
        end
        if (op1_reg == v3alu_pkg::OP_DOT)
            wide2_next[0] = dot_sum;
    end

    // stage 3 results for everything but magnitude and normalize
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            as_sat[k] = v3alu_pkg::sat_wide(v3alu_pkg::wide_t'(as2_reg[k]));
            rd_sat[k] = v3alu_pkg::round_sat(wide2_reg[k]);
        end
        side1_next       = '0;
        side1_next.valid = v2_reg;
        side1_next.op    = op2_reg;
        side1_next.ax    = a2_reg[0];
        side1_next.ay    = a2_reg[1];
        side1_next.az    = a2_reg[2];
        unique case (op2_reg)
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB:
            begin
                side1_next.res.x   = as_sat[0].val;
                side1_next.res.y   = as_sat[1].val;
                side1_next.res.z   = as_sat[2].val;
                side1_next.res.ovf = as_sat[0].ovf | as_sat[1].ovf | as_sat[2].ovf;
            end
            v3alu_pkg::OP_SCALE, v3alu_pkg::OP_CROSS:
            begin
                side1_next.res.x   = rd_sat[0].val;
                side1_next.res.y   = rd_sat[1].val;
                side1_next.res.z   = rd_sat[2].val;
                side1_next.res.ovf = rd_sat[0].ovf | rd_sat[1].ovf | rd_sat[2].ovf;
            end
            v3alu_pkg::OP_DOT:
            begin
                side1_next.res.s   = rd_sat[0].val;
                side1_next.res.ovf = rd_sat[0].ovf;
            end
            default:
            begin
                // magnitude and normalize finish later; unused opcode stays zero
            end
        endcase
    end

    v3alu_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sq2_reg),
        .root (mag)
    );

    assign s1a[0] = side1_reg[v3alu_pkg::SQRT_STAGES-1].ax;
    assign s1a[1] = side1_reg[v3alu_pkg::SQRT_STAGES-1].ay;
    assign s1a[2] = side1_reg[v3alu_pkg::SQRT_STAGES-1].az;

    always_comb
    begin
        side2_next       = side1_reg[v3alu_pkg::SQRT_STAGES-1];
        side2_next.mzero = (mag == '0);
        if (side2_next.op == v3alu_pkg::OP_MAG)
        begin
            side2_next.res.ovf = mag[v3alu_pkg::W-1];
            side2_next.res.s   = mag[v3alu_pkg::W-1] ? v3alu_pkg::MAX_VAL
                                                     : v3alu_pkg::word_t'(mag);
        end
        for (int k = 0; k < 3; k++)
            div_num[k] = {v3alu_pkg::abs_word(s1a[k]), {v3alu_pkg::F{1'b0}}};
    end

    v3alu_div u_div (
        .clk (clk),
        .en  (adv),
        .num (div_num),
        .den (mag),
        .quo (div_quo)
    );

    assign s2a[0] = side2_reg[v3alu_pkg::DIV_STAGES-1].ax;
    assign s2a[1] = side2_reg[v3alu_pkg::DIV_STAGES-1].ay;
    assign s2a[2] = side2_reg[v3alu_pkg::DIV_STAGES-1].az;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            nrm_sat[k] = v3alu_pkg::div_sat(div_quo[k], s2a[k][v3alu_pkg::W-1]);
        out_res_next = side2_reg[v3alu_pkg::DIV_STAGES-1].res;
        if (side2_reg[v3alu_pkg::DIV_STAGES-1].op == v3alu_pkg::OP_NORM)
        begin
            if (side2_reg[v3alu_pkg::DIV_STAGES-1].mzero)
            begin
                // zero length: pass a through
                out_res_next.x   = s2a[0];
                out_res_next.y   = s2a[1];
                out_res_next.z   = s2a[2];
                out_res_next.ovf = 1'b0;
            end
            else
            begin
                out_res_next.x   = nrm_sat[0].val;
                out_res_next.y   = nrm_sat[1].val;
                out_res_next.z   = nrm_sat[2].val;
                out_res_next.ovf = nrm_sat[0].ovf | nrm_sat[1].ovf | nrm_sat[2].ovf;
            end
            out_res_next.s = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < v3alu_pkg::SQRT_STAGES; j++)
                side1_reg[j] <= '0;
            for (int j = 0; j < v3alu_pkg::DIV_STAGES; j++)
                side2_reg[j] <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= operand.valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= side2_reg[v3alu_pkg::DIV_STAGES-1].valid;
            side1_reg[0]  <= side1_next;
            for (int j = 1; j < v3alu_pkg::SQRT_STAGES; j++)
                side1_reg[j] <= side1_reg[j-1];
            side2_reg[0]  <= side2_next;
            for (int j = 1; j < v3alu_pkg::DIV_STAGES; j++)
                side2_reg[j] <= side2_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg     <= op_in;
            a1_reg      <= a_in;
            prod_reg    <= prod_next;
            as1_reg     <= as1_next;
            op2_reg     <= op1_reg;
            a2_reg      <= a1_reg;
            as2_reg     <= as1_reg;
            wide2_reg   <= wide2_next;
            sq2_reg     <= dot_sum[v3alu_pkg::SQ_W-1:0];
            out_res_reg <= out_res_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.res_x      = out_res_reg.x;
    assign result.res_y      = out_res_reg.y;
    assign result.res_z      = out_res_reg.z;
    assign result.res_scalar = out_res_reg.s;
    assign result.overflow   = out_res_reg.ovf;

endmodule

>>> src/v3alu_checker.sv
`include "vector3_arithmetic_unit_defines.svh"

module v3alu_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic signed [v3alu_pkg::W-1:0] res_x,
    input logic signed [v3alu_pkg::W-1:0] res_y,
    input logic signed [v3alu_pkg::W-1:0] res_z,
    input logic signed [v3alu_pkg::W-1:0] res_scalar,
    input logic                   overflow
);

    // input side moves whenever the output register can move
    `V3ALU_ASSERT_NOW(a_ready_link, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "ready does not follow output register")

    `V3ALU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_x) && $stable(res_y) && $stable(res_z) && $stable(res_scalar) && $stable(overflow), "stalled result changed")

    // a scalar result never comes with a vector result
    `V3ALU_ASSERT_NOW(a_scalar_excl, out_valid && res_scalar != 0, res_x == 0 && res_y == 0 && res_z == 0, "scalar and vector result both nonzero")

    `V3ALU_ASSERT_NOW(a_scalar_sat, out_valid && overflow && res_scalar != 0, res_scalar == v3alu_pkg::MAX_VAL || res_scalar == v3alu_pkg::MIN_VAL, "overflowed scalar not saturated")

endmodule

bind vector3_arithmetic_unit v3alu_checker u_v3alu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (operand.valid),
    .in_ready   (operand.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .res_x      (result.res_x),
    .res_y      (result.res_y),
    .res_z      (result.res_z),
    .res_scalar (result.res_scalar),
    .overflow   (result.overflow)
);

>>> tb/sv/v3alu_scoreboard.sv
`timescale 1ns / 100ps

module v3alu_scoreboard (
    input  logic         clk,
    input  logic         rst_n,
    v3alu_in_if.sink     operand,
    v3alu_out_if.sink    result,
    output int           errors,
    output int           pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] s;
        logic               ovf;
    } vec_res_t;

    vec_res_t expected_q[$];

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] rnd(input logic signed [127:0] v);
        return (v + 128'sd32768) >>> 16;
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic vec_res_t compute_vector_op(input logic [2:0] op,
            input logic signed [31:0] ax, ay, az, bx, by, bz);
        vec_res_t              r;
        logic signed [127:0]   a [3];
        logic signed [127:0]   b [3];
        logic signed [127:0]   acc;
        logic signed [127:0]   q;
        logic [127:0]          mag;
        logic [63:0]           m;
        logic                  ov;
        a[0] = ax; a[1] = ay; a[2] = az;
        b[0] = bx; b[1] = by; b[2] = bz;
        ov = 1'b0;
        r.x = 0; r.y = 0; r.z = 0; r.s = 0;
        case (op)
            v3alu_pkg::OP_ADD:
            begin
                r.x = clamp(a[0] + b[0], ov);
                r.y = clamp(a[1] + b[1], ov);
                r.z = clamp(a[2] + b[2], ov);
            end
            v3alu_pkg::OP_SUB:
            begin
                r.x = clamp(a[0] - b[0], ov);
                r.y = clamp(a[1] - b[1], ov);
                r.z = clamp(a[2] - b[2], ov);
            end
            v3alu_pkg::OP_SCALE:
            begin
                r.x = clamp(rnd(a[0] * b[0]), ov);
                r.y = clamp(rnd(a[1] * b[0]), ov);
                r.z = clamp(rnd(a[2] * b[0]), ov);
            end
            v3alu_pkg::OP_DOT:
                r.s = clamp(rnd(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), ov);
            v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM:
            begin
                acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                m = root_floor(acc);
                if (op == v3alu_pkg::OP_MAG)
                begin
                    if (m > 64'd2147483647)
                    begin
                        ov = 1'b1;
                        r.s = 32'sh7fffffff;
                    end
                    else
                        r.s = m[31:0];
                end
                else if (m == 0)
                begin
                    r.x = ax; r.y = ay; r.z = az;
                end
                else
                begin
                    // truncating divide on magnitudes, sign restored afterward
                    mag = a[0] < 0 ? -a[0] : a[0];
                    q = (mag << 16) / m;
                    r.x = clamp(a[0] < 0 ? -q : q, ov);
                    mag = a[1] < 0 ? -a[1] : a[1];
                    q = (mag << 16) / m;
                    r.y = clamp(a[1] < 0 ? -q : q, ov);
                    mag = a[2] < 0 ? -a[2] : a[2];
                    q = (mag << 16) / m;
                    r.z = clamp(a[2] < 0 ? -q : q, ov);
                end
            end
            v3alu_pkg::OP_CROSS:
            begin
                r.x = clamp(rnd(a[1] * b[2] - a[2] * b[1]), ov);
                r.y = clamp(rnd(a[2] * b[0] - a[0] * b[2]), ov);
                r.z = clamp(rnd(a[0] * b[1] - a[1] * b[0]), ov);
            end
            default: ;
        endcase
        r.ovf = ov;
        return r;
    endfunction

    always @(posedge clk)
    begin
        vec_res_t e;
        if (rst_n && operand.valid && operand.ready)
            expected_q.push_back(compute_vector_op(operand.opcode, operand.a_x, operand.a_y,
                operand.a_z, operand.b_x, operand.b_y, operand.b_z));
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word x=%h", $time, result.res_x);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result.res_x !== e.x || result.res_y !== e.y || result.res_z !== e.z ||
                    result.res_scalar !== e.s || result.overflow !== e.ovf)
                begin
                    errors++;
                    $display("%0t: mismatch expected x=%h y=%h z=%h s=%h ovf=%b", $time,
                        e.x, e.y, e.z, e.s, e.ovf);
                    $display("%0t:          actual   x=%h y=%h z=%h s=%h ovf=%b", $time,
                        result.res_x, result.res_y, result.res_z, result.res_scalar,
                        result.overflow);
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

>>> tb/sv/tb_vector3_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_vector3_arithmetic_unit;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   src_idle;
    int   snk_idle;

    v3alu_in_if  operand ();
    v3alu_out_if result ();

    vector3_arithmetic_unit dut (.clk(clk), .rst_n(rst_n), .operand(operand.sink),
        .result(result.source));

    v3alu_scoreboard checker_i (.clk(clk), .rst_n(rst_n), .operand(operand.sink),
        .result(result.sink), .errors(errors), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("FAIL vector3_arithmetic_unit");
                $finish;
            end
        end
    end

    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= snk_idle);

    function automatic logic [31:0] rand_comp(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(32'h7ffff) - 32'h40000;
            2: return 32'h80000000 + $urandom_range(3);
            3: return 32'h7fffffff - $urandom_range(3);
            4: return $urandom_range(3) - 1;
            default: return $urandom_range(20'hfffff) - 32'h80000;
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [31:0] ax, ay, az, bx, by, bz);
        while ($urandom_range(99) < src_idle)
        begin
            operand.valid <= 1'b0;
            @(posedge clk);
        end
        operand.valid  <= 1'b1;
        operand.opcode <= op;
        operand.a_x <= ax; operand.a_y <= ay; operand.a_z <= az;
        operand.b_x <= bx; operand.b_y <= by; operand.b_z <= bz;
        @(posedge clk);
        while (!operand.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(5);
            send_word(3'($urandom_range(7)), rand_comp(k), rand_comp($urandom_range(5)),
                rand_comp(k), rand_comp($urandom_range(5)), rand_comp(k),
                rand_comp($urandom_range(5)));
        end
    endtask

    initial
    begin
        src_idle = 0;
        snk_idle = 0;
        rst_n = 1'b0;
        operand.valid  = 1'b0;
        operand.opcode = '0;
        operand.a_x = '0; operand.a_y = '0; operand.a_z = '0;
        operand.b_x = '0; operand.b_y = '0; operand.b_z = '0;
        result.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode on extremes, zero and tiny vectors
        for (int op = 0; op < 8; op++)
        begin
            send_word(3'(op), 32'h7fffffff, 32'h80000000, 32'h00010000,
                32'h80000000, 32'h7fffffff, 32'hffff0000);
            send_word(3'(op), 0, 0, 0, 0, 0, 0);
            send_word(3'(op), 1, 32'hffffffff, 0, 32'h00008000, 32'hffff8000, 1);
        end

        src_idle = 36; snk_idle = 69;
        send_random(330);
        src_idle = 69; snk_idle = 36;
        send_random(330);
        src_idle = 0; snk_idle = 0;
        send_random(340);
        operand.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS vector3_arithmetic_unit");
        else
            $display("FAIL vector3_arithmetic_unit");
        $finish;
    end
endmodule
